[rtl/teg_pkg.sv]
// Shared constants, types and helper functions of the tetrahedron geometry core.
`timescale 1ns / 1ps
package teg_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int GRAD_FRAC_BITS = 16;
    localparam int COORD_FRAC     = 8;
    localparam int DIV_SHIFT      = GRAD_FRAC_BITS + COORD_FRAC;

    localparam int FIELD_W  = 16;
    localparam int NUM_IN   = 12;
    localparam int IN_W     = FIELD_W * NUM_IN;
    localparam int NUM_LANE = 9;
    localparam int NUM_NODE = 4;

    localparam int A_W     = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * A_W;
    localparam int COF_W   = PROD_W + 1;
    localparam int DETP_W  = A_W + COF_W;
    localparam int DET_W   = DETP_W + 2;
    localparam int MAG_W   = DET_W;
    localparam int NUM_W   = COF_W + DIV_SHIFT;
    localparam int Q_W     = 32;
    localparam int G_W     = 32;
    localparam int SUM_W   = G_W + 2;
    localparam int CMP_W   = (NUM_W - Q_W > MAG_W) ? NUM_W - Q_W : MAG_W;
    localparam int VOL_DIG = (MAG_W + 3) / 4;
    localparam int VS_W    = 4 * VOL_DIG;

    localparam int DET_OUT_W = 52;
    localparam int VOL_OUT_W = 50;
    localparam int OUT_W     = 200;

    typedef logic signed [A_W-1:0]       a_t;
    typedef logic signed [PROD_W-1:0]    prod_t;
    typedef logic signed [COF_W-1:0]     cof_t;
    typedef logic signed [DETP_W-1:0]    detp_t;
    typedef logic signed [DET_W-1:0]     det_t;
    typedef logic [COF_W-1:0]            mag_t;
    typedef logic [MAG_W-1:0]            dmag_t;
    typedef logic [NUM_W-1:0]            num_t;
    typedef logic [CMP_W-1:0]            cmp_t;
    typedef logic [Q_W-1:0]              q_t;
    typedef logic [VS_W-1:0]             vs_t;
    typedef logic signed [G_W-1:0]       grad_t;
    typedef logic signed [SUM_W-1:0]     sum_t;
    typedef logic signed [DET_OUT_W-1:0] det_out_t;
    typedef logic signed [VOL_OUT_W-1:0] vol_out_t;
    typedef logic [1:0]                  node_t;

    typedef cof_t [NUM_LANE-1:0] cof_vec_t;

    localparam node_t LAST_NODE = node_t'(NUM_NODE - 1);
    localparam grad_t G_MAX     = {1'b0, {(G_W-1){1'b1}}};
    localparam grad_t G_MIN     = {1'b1, {(G_W-1){1'b0}}};

    // determinant and cofactors, lane index is row * 3 + column
    typedef struct packed {
        det_t     det;
        cof_vec_t cof;
    } front_t;

    typedef struct packed {
        logic [NUM_LANE-1:0] neg;
        logic [NUM_LANE-1:0] sat;
        logic                sing;
        det_t                det;
        logic                det_neg;
    } div_info_t;

    typedef struct packed {
        q_t [NUM_LANE-1:0]   quo;
        div_info_t           info;
        vs_t                 vquo;
    } div_out_t;

    typedef struct packed {
        grad_t [NUM_NODE-1:0][2:0] g;
        det_t                      det;
        det_t                      vol;
        logic                      sing;
    } grad_set_t;

    typedef struct packed {
        node_t    node;
        grad_t    grad_x;
        grad_t    grad_y;
        grad_t    grad_z;
        det_out_t det_value;
        vol_out_t volume;
        logic     singular;
        logic     last;
    } res_t;

    function automatic a_t coord(logic [FIELD_W-1:0] f);
        return a_t'($signed(f[COORD_WIDTH-1:0]));
    endfunction

    function automatic grad_t sat_sum(sum_t v);
        if (v > sum_t'(G_MAX)) begin
            return G_MAX;
        end else if (v < sum_t'(G_MIN)) begin
            return G_MIN;
        end
        return grad_t'(v);
    endfunction

    // one radix-16 digit of a divide by six: returns {quotient digit, remainder}
    function automatic logic [6:0] div6_digit(logic [2:0] r, logic [3:0] d);
        logic [6:0]  x;
        logic [12:0] p;
        logic [3:0]  q;
        logic [6:0]  m6;
        x  = {r, d};
        p  = 13'(x) * 13'd43;
        q  = p[11:8];
        m6 = 7'(q) * 7'd6;
        return {q, 3'(x - m6)};
    endfunction

endpackage

[rtl/tetra_element_geometry_core.sv]
// Output: node 0 is presented first and nodes 1-3 follow in order, one result per cycle
//   while m_tready stays high.
// Throughput: the output register takes a new element only when it is free or node 3 is taken.
// All stages advance together and hold while a finished element waits for the output.
// Reset (aresetn low, synchronous) clears every valid bit; data registers are not reset.
`timescale 1ns / 1ps
module tetra_element_geometry_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z
    input  logic [teg_pkg::IN_W-1:0]     s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // node, grad_x, grad_y, grad_z, det_value, volume
    output logic [teg_pkg::OUT_W-1:0]    m_tdata,
    // singular
    output logic                         m_tuser,
    output logic                         m_tlast
);

    logic               adv;
    logic               fr_valid, dv_valid, gr_valid, take;
    teg_pkg::front_t    fr_data;
    teg_pkg::div_out_t  dv_data;
    teg_pkg::grad_set_t gr_set;
    teg_pkg::res_t      res;

    assign adv      = !gr_valid || take;
    assign s_tready = adv;

    teg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (fr_valid),
        .out_data  (fr_data)
    );

    teg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_data   (fr_data),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    teg_grad u_grad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (dv_valid),
        .in_data   (dv_data),
        .out_valid (gr_valid),
        .out_set   (gr_set)
    );

    teg_serial u_serial (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (gr_valid),
        .in_set   (gr_set),
        .take     (take),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .res      (res)
    );

    assign m_tdata = {res.volume, res.det_value, res.grad_z, res.grad_y, res.grad_x, res.node};
    assign m_tuser = res.singular;
    assign m_tlast = res.last;

    a_last_node: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> res.node == teg_pkg::LAST_NODE)
        else $error("tlast on a node other than 3");

    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> res.grad_x == '0 && res.grad_y == '0 && res.grad_z == '0
                                && res.det_value == '0 && res.volume == '0)
        else $error("singular element with nonzero payload");

    a_node_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && res.node == $past(res.node) + 2'd1)
        else $error("node sequence broken");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

endmodule

[rtl/teg_front.sv]
// Front pipeline: edge Jacobian, cofactor products, cofactors and determinant.
`timescale 1ns / 1ps
module teg_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [teg_pkg::IN_W-1:0]    in_data,
    output logic                        out_valid,
    output teg_pkg::front_t             out_data
);

    localparam int NXT1 [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};

    logic [4:0] valid_reg;

    teg_pkg::a_t      a1_next [3][3];
    teg_pkg::a_t      a1_reg  [3][3];
    teg_pkg::prod_t   pa_next [3][3];
    teg_pkg::prod_t   pb_next [3][3];
    teg_pkg::prod_t   pa_reg  [3][3];
    teg_pkg::prod_t   pb_reg  [3][3];
    teg_pkg::a_t      ar2_reg [3];
    teg_pkg::a_t      ar3_reg [3];
    teg_pkg::cof_vec_t cof3_next, cof3_reg, cof4_reg, cof5_reg;
    teg_pkg::detp_t   dp4_next [3];
    teg_pkg::detp_t   dp4_reg  [3];
    teg_pkg::det_t    det5_next, det5_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                a1_next[r][c] = teg_pkg::a_t'(
                    teg_pkg::coord(in_data[((c+1)*3+r)*teg_pkg::FIELD_W +: teg_pkg::FIELD_W])
                    - teg_pkg::coord(in_data[r*teg_pkg::FIELD_W +: teg_pkg::FIELD_W]));
                pa_next[r][c] = teg_pkg::prod_t'(a1_reg[NXT1[c]][NXT1[r]])
                              * teg_pkg::prod_t'(a1_reg[NXT2[c]][NXT2[r]]);
                pb_next[r][c] = teg_pkg::prod_t'(a1_reg[NXT1[c]][NXT2[r]])
                              * teg_pkg::prod_t'(a1_reg[NXT2[c]][NXT1[r]]);
                cof3_next[r*3+c] = teg_pkg::cof_t'(pa_reg[r][c])
                                 - teg_pkg::cof_t'(pb_reg[r][c]);
            end
        end
        for (int c = 0; c < 3; c++) begin
            dp4_next[c] = teg_pkg::detp_t'(ar3_reg[c])
                        * teg_pkg::detp_t'($signed(cof3_reg[c*3]));
        end
        det5_next = teg_pkg::det_t'(dp4_reg[0]) + teg_pkg::det_t'(dp4_reg[1])
                  + teg_pkg::det_t'(dp4_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_reg   <= a1_next;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            for (int c = 0; c < 3; c++) begin
                ar2_reg[c] <= a1_reg[0][c];
            end
            ar3_reg  <= ar2_reg;
            cof3_reg <= cof3_next;
            dp4_reg  <= dp4_next;
            cof4_reg <= cof3_reg;
            det5_reg <= det5_next;
            cof5_reg <= cof4_reg;
        end
    end

    assign out_valid    = valid_reg[4];
    assign out_data.det = det5_reg;
    assign out_data.cof = cof5_reg;

endmodule

[rtl/teg_div.sv]
// Nine pipelined restoring dividers for the inverse entries, plus divide-by-six for volume.
`timescale 1ns / 1ps
module teg_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  teg_pkg::front_t   in_data,
    output logic              out_valid,
    output teg_pkg::div_out_t out_data
);

    localparam int QW = teg_pkg::Q_W;
    localparam int NL = teg_pkg::NUM_LANE;

    // magnitude stage
    logic                  e0_valid_reg;
    teg_pkg::mag_t         mag_next [NL];
    teg_pkg::mag_t         mag_reg  [NL];
    logic [NL-1:0]         cneg_reg;
    teg_pkg::dmag_t        dmag_next, dmag_reg;
    teg_pkg::det_t         det0_reg;
    logic                  dneg0_reg;
    logic                  sing0_reg;

    // divider stages, index 0 holds the prepared operands
    logic [QW:0]           sv_reg;
    teg_pkg::dmag_t        rem_next [QW+1][NL];
    teg_pkg::dmag_t        rem_reg  [QW+1][NL];
    teg_pkg::q_t           nq_next  [QW+1][NL];
    teg_pkg::q_t           nq_reg   [QW+1][NL];
    teg_pkg::dmag_t        d_next   [QW+1];
    teg_pkg::dmag_t        d_reg    [QW+1];
    teg_pkg::div_info_t    info_next [QW+1];
    teg_pkg::div_info_t    info_reg  [QW+1];
    teg_pkg::vs_t          vs_next  [QW+1];
    teg_pkg::vs_t          vs_reg   [QW+1];
    logic [2:0]            vr_next  [QW+1];
    logic [2:0]            vr_reg   [QW+1];

    always_comb begin
        teg_pkg::cof_t   cv;
        teg_pkg::num_t   num;
        logic [teg_pkg::MAG_W:0] t;
        logic            ge;
        logic [6:0]      qr;

        for (int l = 0; l < NL; l++) begin
            cv = in_data.cof[l];
            mag_next[l] = cv[teg_pkg::COF_W-1] ? teg_pkg::mag_t'(-cv) : teg_pkg::mag_t'(cv);
        end
        dmag_next = in_data.det[teg_pkg::DET_W-1] ? teg_pkg::dmag_t'(-in_data.det)
                                                  : teg_pkg::dmag_t'(in_data.det);

        // scale numerators, flag quotients of 2^32 and up
        for (int l = 0; l < NL; l++) begin
            num = {mag_reg[l], {teg_pkg::DIV_SHIFT{1'b0}}};
            info_next[0].sat[l] = teg_pkg::cmp_t'(num >> QW) >= teg_pkg::cmp_t'(dmag_reg);
            info_next[0].neg[l] = cneg_reg[l] ^ dneg0_reg;
            rem_next[0][l]      = teg_pkg::dmag_t'(num >> QW);
            nq_next[0][l]       = num[QW-1:0];
        end
        info_next[0].sing    = sing0_reg;
        info_next[0].det     = det0_reg;
        info_next[0].det_neg = dneg0_reg;
        d_next[0]  = dmag_reg;
        vs_next[0] = teg_pkg::vs_t'(dmag_reg);
        vr_next[0] = '0;

        // one quotient bit per stage
        for (int k = 1; k <= QW; k++) begin
            for (int l = 0; l < NL; l++) begin
                t  = {rem_reg[k-1][l], nq_reg[k-1][l][QW-1]};
                ge = t >= {1'b0, d_reg[k-1]};
                rem_next[k][l] = ge ? teg_pkg::dmag_t'(t - {1'b0, d_reg[k-1]})
                                    : teg_pkg::dmag_t'(t);
                nq_next[k][l]  = {nq_reg[k-1][l][QW-2:0], ge};
            end
            d_next[k]    = d_reg[k-1];
            info_next[k] = info_reg[k-1];
            if (k - 1 < teg_pkg::VOL_DIG) begin
                qr = teg_pkg::div6_digit(vr_reg[k-1], vs_reg[k-1][teg_pkg::VS_W-1 -: 4]);
                vs_next[k] = {vs_reg[k-1][teg_pkg::VS_W-5:0], qr[6:3]};
                vr_next[k] = qr[2:0];
            end else begin
                vs_next[k] = vs_reg[k-1];
                vr_next[k] = vr_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e0_valid_reg <= 1'b0;
            sv_reg       <= '0;
        end else if (adv) begin
            e0_valid_reg <= in_valid;
            sv_reg       <= {sv_reg[QW-1:0], e0_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg   <= mag_next;
            for (int l = 0; l < NL; l++) begin
                cneg_reg[l] <= in_data.cof[l][teg_pkg::COF_W-1];
            end
            dmag_reg  <= dmag_next;
            det0_reg  <= in_data.det;
            dneg0_reg <= in_data.det[teg_pkg::DET_W-1];
            sing0_reg <= (in_data.det == '0);
            rem_reg   <= rem_next;
            nq_reg    <= nq_next;
            d_reg     <= d_next;
            info_reg  <= info_next;
            vs_reg    <= vs_next;
            vr_reg    <= vr_next;
        end
    end

    assign out_valid = sv_reg[QW];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            out_data.quo[l] = nq_reg[QW][l];
        end
        out_data.info = info_reg[QW];
        out_data.vquo = vs_reg[QW];
    end

endmodule

[rtl/teg_grad.sv]
// Gradient stages: sign and saturate inverse entries, signed volume, node 0 row.
`timescale 1ns / 1ps
module teg_grad (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  teg_pkg::div_out_t  in_data,
    output logic               out_valid,
    output teg_pkg::grad_set_t out_set
);

    localparam int NL = teg_pkg::NUM_LANE;

    logic [1:0]         valid_reg;
    teg_pkg::grad_t     g1_next [NL];
    teg_pkg::grad_t     g1_reg  [NL];
    teg_pkg::det_t      vol1_next, vol1_reg;
    teg_pkg::det_t      det1_reg;
    logic               sing1_reg;
    teg_pkg::grad_set_t set_next, set_reg;

    always_comb begin
        teg_pkg::q_t   q;
        teg_pkg::det_t vmag;
        teg_pkg::sum_t s;

        for (int l = 0; l < NL; l++) begin
            q = in_data.quo[l];
            if (in_data.info.sing) begin
                g1_next[l] = '0;
            end else if (in_data.info.neg[l]) begin
                if (in_data.info.sat[l] || q > teg_pkg::q_t'(teg_pkg::G_MIN)) begin
                    g1_next[l] = teg_pkg::G_MIN;
                end else begin
                    g1_next[l] = teg_pkg::grad_t'(teg_pkg::q_t'(0) - q);
                end
            end else begin
                if (in_data.info.sat[l] || q[teg_pkg::Q_W-1]) begin
                    g1_next[l] = teg_pkg::G_MAX;
                end else begin
                    g1_next[l] = teg_pkg::grad_t'(q);
                end
            end
        end
        vmag      = teg_pkg::det_t'(in_data.vquo);
        vol1_next = in_data.info.det_neg ? -vmag : vmag;

        // node 0 is the negated sum of the three rows
        for (int c = 0; c < 3; c++) begin
            s = teg_pkg::sum_t'(g1_reg[c]) + teg_pkg::sum_t'(g1_reg[3+c])
              + teg_pkg::sum_t'(g1_reg[6+c]);
            set_next.g[0][c] = teg_pkg::sat_sum(-s);
            for (int r = 0; r < 3; r++) begin
                set_next.g[r+1][c] = g1_reg[r*3+c];
            end
        end
        set_next.det  = det1_reg;
        set_next.vol  = vol1_reg;
        set_next.sing = sing1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g1_reg    <= g1_next;
            vol1_reg  <= vol1_next;
            det1_reg  <= in_data.info.det;
            sing1_reg <= in_data.info.sing;
            set_reg   <= set_next;
        end
    end

    assign out_valid = valid_reg[1];
    assign out_set   = set_reg;

endmodule

[rtl/teg_serial.sv]
// Output register that issues the four node results of one element in order.
`timescale 1ns / 1ps
module teg_serial (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  teg_pkg::grad_set_t in_set,
    output logic               take,
    output logic               m_valid,
    input  logic               m_ready,
    output teg_pkg::res_t      res
);

    logic               valid_reg, valid_next;
    teg_pkg::node_t     node_reg, node_next;
    teg_pkg::grad_set_t set_reg, set_next;

    // free, or the node 3 transfer completes this cycle
    assign take = !valid_reg || (m_ready && node_reg == teg_pkg::LAST_NODE);

    always_comb begin
        valid_next = valid_reg;
        node_next  = node_reg;
        set_next   = set_reg;
        if (take) begin
            valid_next = in_valid;
            node_next  = '0;
            set_next   = in_set;
        end else if (m_ready) begin
            node_next = node_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            node_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            node_reg  <= node_next;
        end
    end

    always_ff @(posedge aclk) begin
        set_reg <= set_next;
    end

    assign m_valid       = valid_reg;
    assign res.node      = node_reg;
    assign res.grad_x    = set_reg.g[node_reg][0];
    assign res.grad_y    = set_reg.g[node_reg][1];
    assign res.grad_z    = set_reg.g[node_reg][2];
    assign res.det_value = teg_pkg::det_out_t'(set_reg.det);
    assign res.volume    = teg_pkg::vol_out_t'(set_reg.vol);
    assign res.singular  = set_reg.sing;
    assign res.last      = (node_reg == teg_pkg::LAST_NODE);

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the tetrahedron geometry core: gradients, determinant, volume.
`timescale 1ns / 1ps
module tb_top;

    localparam int HOLD_AT   = 120;
    localparam int WD_LIMIT  = 3000;
    localparam int BUSY_LO   = 300;
    localparam int BUSY_HI   = 700;
    localparam longint BIG_Q = 64'sd1 << 33;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [teg_pkg::IN_W-1:0]      s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [teg_pkg::OUT_W-1:0]     m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;

    logic [teg_pkg::IN_W-1:0] elem_q[$];
    teg_pkg::res_t            grad_q[$];
    int              sent_cnt;
    int              res_cnt;
    int              sing_cnt;
    int              err_cnt;
    int              cyc;
    int              quiet_cyc;
    bit              in_fire;

    tetra_element_geometry_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // trunc((num << DIV_SHIFT) / den), capped at 2^33 in magnitude, then clamped
    function automatic longint inv_entry(longint num, longint den);
        bit           neg;
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        longint       v;
        neg = (num < 0) != (den < 0);
        n = 128'(num < 0 ? -num : num);
        d = 128'(den < 0 ? -den : den);
        q = (n << teg_pkg::DIV_SHIFT) / d;
        if (q >= 128'(BIG_Q)) begin
            q = 128'(BIG_Q);
        end
        v = longint'(q);
        return clamp32(neg ? -v : v);
    endfunction

    task automatic predict_gradients(logic [teg_pkg::IN_W-1:0] e);
        longint a[3][3];
        longint cf[3][3];
        longint g[4][3];
        longint det;
        longint vol;
        bit     sing;
        teg_pkg::res_t r;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                a[i][j] = longint'($signed(e[16*((j+1)*3+i) +: 16]))
                        - longint'($signed(e[16*i +: 16]));
            end
        end
        cf[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
        cf[0][1] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
        cf[0][2] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
        cf[1][0] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
        cf[1][1] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
        cf[1][2] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
        cf[2][0] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
        cf[2][1] = a[0][1]*a[2][0] - a[0][0]*a[2][1];
        cf[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
        det  = a[0][0]*cf[0][0] + a[0][1]*cf[1][0] + a[0][2]*cf[2][0];
        vol  = det / 6;
        sing = (det == 0);
        for (int j = 0; j < 3; j++) begin
            g[0][j] = 0;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                g[i+1][j] = sing ? 0 : inv_entry(cf[i][j], det);
                g[0][j] -= g[i+1][j];
            end
        end
        for (int j = 0; j < 3; j++) begin
            g[0][j] = clamp32(g[0][j]);
        end
        for (int k = 0; k < teg_pkg::NUM_NODE; k++) begin
            r.node      = teg_pkg::node_t'(k);
            r.grad_x    = teg_pkg::grad_t'(g[k][0]);
            r.grad_y    = teg_pkg::grad_t'(g[k][1]);
            r.grad_z    = teg_pkg::grad_t'(g[k][2]);
            r.det_value = teg_pkg::det_out_t'(sing ? 0 : det);
            r.volume    = teg_pkg::vol_out_t'(sing ? 0 : vol);
            r.singular  = sing;
            r.last      = (teg_pkg::node_t'(k) == teg_pkg::LAST_NODE);
            grad_q.push_back(r);
        end
    endtask

    function automatic logic [teg_pkg::IN_W-1:0] pack_elem(int v[12]);
        logic [teg_pkg::IN_W-1:0] e;
        for (int i = 0; i < 12; i++) begin
            e[16*i +: 16] = 16'(v[i]);
        end
        return e;
    endfunction

    function automatic int rnd16();
        return int'($signed(16'($urandom)));
    endfunction

    // drive the input side
    always @(negedge aclk) begin
        bit idle;
        idle = (cyc < BUSY_LO || cyc > BUSY_HI) && ($urandom_range(99) < 26);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (elem_q.size() != 0 && !idle && !(sent_cnt == HOLD_AT && grad_q.size() != 0)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= elem_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && !((cyc < BUSY_LO || cyc > BUSY_HI) && ($urandom_range(99) < 26));
    end

    // accept transfers on both sides and check results
    always @(posedge aclk) begin
        teg_pkg::res_t exp_r;
        cyc++;
        in_fire = aresetn && s_tvalid && s_tready;
        if (in_fire) begin
            predict_gradients(s_tdata);
            sent_cnt++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (grad_q.size() == 0) begin
                $error("result transfer with nothing expected");
                err_cnt++;
            end else begin
                exp_r = grad_q.pop_front();
                res_cnt++;
                if (m_tuser) sing_cnt++;
                if (m_tdata[1:0] !== exp_r.node) begin
                    $error("node exp %0d got %0d", exp_r.node, m_tdata[1:0]);
                    err_cnt++;
                end
                if (m_tdata[33:2] !== exp_r.grad_x) begin
                    $error("grad_x exp %0d got %0d", exp_r.grad_x, $signed(m_tdata[33:2]));
                    err_cnt++;
                end
                if (m_tdata[65:34] !== exp_r.grad_y) begin
                    $error("grad_y exp %0d got %0d", exp_r.grad_y, $signed(m_tdata[65:34]));
                    err_cnt++;
                end
                if (m_tdata[97:66] !== exp_r.grad_z) begin
                    $error("grad_z exp %0d got %0d", exp_r.grad_z, $signed(m_tdata[97:66]));
                    err_cnt++;
                end
                if (m_tdata[149:98] !== exp_r.det_value) begin
                    $error("det_value exp %0d got %0d", exp_r.det_value,
                           $signed(m_tdata[149:98]));
                    err_cnt++;
                end
                if (m_tdata[199:150] !== exp_r.volume) begin
                    $error("volume exp %0d got %0d", exp_r.volume, $signed(m_tdata[199:150]));
                    err_cnt++;
                end
                if (m_tuser !== exp_r.singular) begin
                    $error("singular exp %0d got %0d", exp_r.singular, m_tuser);
                    err_cnt++;
                end
                if (m_tlast !== exp_r.last) begin
                    $error("last exp %0d got %0d", exp_r.last, m_tlast);
                    err_cnt++;
                end
            end
        end
        if (in_fire || (m_tvalid && m_tready)) begin
            quiet_cyc = 0;
        end else begin
            quiet_cyc++;
        end
    end

    initial begin
        wait (quiet_cyc >= WD_LIMIT);
        $display("timeout: no transfer for %0d cycles", WD_LIMIT);
        $display("FAIL tetra_element_geometry_core");
        $finish;
    end

    initial begin
        int v[12];
        int sel;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        sent_cnt = 0;
        res_cnt  = 0;
        sing_cnt = 0;
        err_cnt  = 0;
        cyc      = 0;
        quiet_cyc = 0;

        // directed: degenerate, unit, extremes, tiny determinant, saturating inverse
        v = '{default: 0};
        elem_q.push_back(pack_elem(v));
        v = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 256};
        elem_q.push_back(pack_elem(v));
        v = '{0, 0, 0, 0, 256, 0, 256, 0, 0, 0, 0, 256};
        elem_q.push_back(pack_elem(v));
        v = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
        elem_q.push_back(pack_elem(v));
        v = '{-32768, -32768, -32768, 32767, -32768, -32768,
              -32768, 32767, -32768, -32768, -32768, 32767};
        elem_q.push_back(pack_elem(v));
        v = '{32767, 32767, 32767, -32768, 32767, 32767,
              32767, -32768, 32767, 32767, 32767, -32768};
        elem_q.push_back(pack_elem(v));
        v = '{0, 0, 0, 32767, 32766, 0, 32766, 32765, 0, 0, 0, 1};
        elem_q.push_back(pack_elem(v));
        v = '{0, 0, 0, 32767, 32766, 0, 32766, 32765, 0, 0, 0, -1};
        elem_q.push_back(pack_elem(v));
        v = '{-32768, 0, 0, -1, 32767, 0, -2, 32767, 0, -32768, 0, 1};
        elem_q.push_back(pack_elem(v));
        v = '{100, 200, 300, 100, 200, 300, 5, 6, 7, 8, 9, 10};
        elem_q.push_back(pack_elem(v));
        v = '{0, 0, 0, 256, 256, 0, 512, 512, 0, 7, -3, 0};
        elem_q.push_back(pack_elem(v));
        v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1};
        elem_q.push_back(pack_elem(v));
        v = '{-21846, 21845, -21846, 21845, -21846, 21845,
              -21846, -21846, 21845, 21845, 21845, -21846};
        elem_q.push_back(pack_elem(v));

        // random: full range, small shapes, and coplanar or collapsed elements
        for (int n = 0; n < 210; n++) begin
            sel = $urandom_range(9);
            for (int i = 0; i < 12; i++) begin
                v[i] = rnd16();
            end
            if (sel < 4) begin
                for (int i = 3; i < 12; i++) begin
                    v[i] = v[i % 3] + $urandom_range(8) - 4;
                end
            end else if (sel == 4) begin
                // fourth vertex in the plane of the other three
                for (int i = 0; i < 3; i++) begin
                    v[i+3] = v[i] + $urandom_range(200) - 100;
                    v[i+6] = v[i] + $urandom_range(200) - 100;
                    v[i+9] = v[i+3] + v[i+6] - v[i];
                end
            end else if (sel == 5) begin
                v[3 * $urandom_range(1, 3) + 0] = v[0];
                v[3 * $urandom_range(1, 3) + 1] = v[1];
                for (int i = 0; i < 3; i++) begin
                    v[9 + i] = v[3 + i];
                end
            end
            elem_q.push_back(pack_elem(v));
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        wait (elem_q.size() == 0 && !s_tvalid);
        wait (grad_q.size() == 0);
        repeat (60) @(posedge aclk);
        if (grad_q.size() != 0) begin
            $error("%0d results never arrived", grad_q.size());
            err_cnt++;
        end
        $display("covered %0d elements, %0d node results, %0d of them singular",
                 sent_cnt, res_cnt, sing_cnt);
        if (err_cnt == 0) begin
            $display("PASS tetra_element_geometry_core");
        end else begin
            $display("FAIL tetra_element_geometry_core");
        end
        $finish;
    end
endmodule
